// ===== design/hcbp_pkg.sv =====
// shared constants, opcodes and transaction types for the huffman code bit packer
`default_nettype none

package hcbp_pkg;

	localparam int ALPHABET_SIZE = 256;
	localparam int MAX_CODE_LEN  = 16;
	localparam int STORE_BITS    = 16;
	localparam int BYTE_BITS     = 8;

	localparam int SYM_W   = 8;
	localparam int CODE_W  = 16;
	localparam int LEN_W   = 5;
	localparam int ADDR_W  = $clog2(ALPHABET_SIZE);
	localparam int LEN_CAP = (MAX_CODE_LEN < STORE_BITS) ? MAX_CODE_LEN : STORE_BITS;
	localparam int ENTRY_W = CODE_W + LEN_W;

	localparam int PEND_W = BYTE_BITS - 1;
	localparam int CNT_W  = $clog2(BYTE_BITS);
	localparam int ACC_W  = PEND_W + CODE_W;
	localparam int TOT_W  = $clog2(ACC_W + 1);

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_ENCODE = 2'd1;
	localparam logic [1:0] OP_FLUSH  = 2'd2;
	localparam logic [1:0] OP_NONE   = 2'd3;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [SYM_W-1:0]  symbol;
		logic [CODE_W-1:0] code_value;
		logic [LEN_W-1:0]  code_length;
	} req_t;

	typedef struct packed {
		logic [BYTE_BITS-1:0] out_byte;
		logic                 last_of_run;
		logic                 unknown_symbol;
		logic                 padded_final;
	} rsp_t;

	// looked-up item handed from the table stage to the packer
	typedef struct packed {
		logic              vld;
		logic [1:0]        opcode;
		logic              loaded;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} lookup_t;

endpackage

`default_nettype wire

// ===== design/hcbp_ram.sv =====
// generic single-port-write, registered-read ram
`default_nettype none

module hcbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/hcbp_table.sv =====
// code table: ram for code and length, loaded marks, lookup stage register
`default_nettype none

module hcbp_table (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	input  wire hcbp_pkg::req_t   req,
	output logic                  req_stall,
	input  wire logic             advance,
	output hcbp_pkg::lookup_t     lookup
);

	logic                             accept;
	logic                             in_range;
	logic [hcbp_pkg::ADDR_W-1:0]      idx;
	logic [hcbp_pkg::LEN_W-1:0]       len_sat;
	logic [hcbp_pkg::CODE_W:0]        code_mask;
	logic [hcbp_pkg::CODE_W-1:0]      wr_code;
	logic                             we;
	logic [hcbp_pkg::ENTRY_W-1:0]     rdata;
	logic [hcbp_pkg::ALPHABET_SIZE-1:0] loaded_q;
	logic                             vld_s1;
	logic [1:0]                       op_s1;
	logic                             loaded_s1;

	assign req_stall = vld_s1 && !advance;
	assign accept    = req_valid && !req_stall;
	assign in_range  = 32'(req.symbol) < hcbp_pkg::ALPHABET_SIZE;
	assign idx       = req.symbol[hcbp_pkg::ADDR_W-1:0];

	// overlong lengths saturate, bits above the length are dropped
	assign len_sat   = (32'(req.code_length) > hcbp_pkg::LEN_CAP) ?
		hcbp_pkg::LEN_W'(hcbp_pkg::LEN_CAP) : req.code_length;
	assign code_mask = ((hcbp_pkg::CODE_W+1)'(1) << len_sat) - (hcbp_pkg::CODE_W+1)'(1);
	assign wr_code   = req.code_value & code_mask[hcbp_pkg::CODE_W-1:0];
	assign we        = accept && (req.opcode == hcbp_pkg::OP_LOAD) && in_range;

	hcbp_ram #(
		.WIDTH (hcbp_pkg::ENTRY_W),
		.DEPTH (hcbp_pkg::ALPHABET_SIZE)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (idx),
		.wdata ({wr_code, len_sat}),
		.re    (accept),
		.raddr (idx),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			loaded_q <= '0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (advance) begin
				vld_s1 <= 1'b0;
			end
			if (we) begin
				loaded_q[idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= req.opcode;
			loaded_s1 <= in_range && loaded_q[idx];
		end
	end

	always_comb begin
		lookup.vld    = vld_s1;
		lookup.opcode = op_s1;
		lookup.loaded = loaded_s1;
		lookup.code   = rdata[hcbp_pkg::ENTRY_W-1:hcbp_pkg::LEN_W];
		lookup.len    = rdata[hcbp_pkg::LEN_W-1:0];
	end

	a_load_marks: assert property (@(posedge clk) disable iff (!arst_n)
		we |=> loaded_q[$past(idx)])
		else $error("loaded mark not set after table load");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !advance |=> vld_s1 && $stable(op_s1))
		else $error("lookup stage lost its transaction while held");

	a_encode_enters: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.opcode == hcbp_pkg::OP_ENCODE) |=>
			vld_s1 && (op_s1 == hcbp_pkg::OP_ENCODE))
		else $error("accepted encode did not reach the lookup stage");

endmodule

`default_nettype wire

// ===== design/hcbp_packer.sv =====
// msb-first bit packer with a two-entry result buffer
`default_nettype none

module hcbp_packer (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire hcbp_pkg::lookup_t lookup,
	output logic                   advance,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output hcbp_pkg::rsp_t         rsp
);

	logic [hcbp_pkg::PEND_W-1:0] pend_bits_q;
	logic [hcbp_pkg::CNT_W-1:0]  pend_cnt_q;
	hcbp_pkg::rsp_t              buf0_q;
	hcbp_pkg::rsp_t              buf1_q;
	logic [1:0]                  buf_cnt_q;

	logic                        pop;
	logic [hcbp_pkg::ACC_W-1:0]  acc;
	logic [hcbp_pkg::TOT_W-1:0]  total;
	logic [hcbp_pkg::TOT_W-1:0]  rem;
	logic [1:0]                  n_bytes;
	logic [hcbp_pkg::ACC_W-1:0]  rem_mask;
	logic [hcbp_pkg::BYTE_BITS-1:0] byte_hi;
	logic [hcbp_pkg::BYTE_BITS-1:0] byte_lo;
	logic [hcbp_pkg::CNT_W:0]    flush_sh;
	logic [hcbp_pkg::BYTE_BITS-1:0] flush_byte;

	logic [1:0]                  n_new;
	hcbp_pkg::rsp_t              r0;
	hcbp_pkg::rsp_t              r1;
	logic [hcbp_pkg::PEND_W-1:0] pend_bits_d;
	logic [hcbp_pkg::CNT_W-1:0]  pend_cnt_d;

	assign rsp_valid = (buf_cnt_q != 2'd0);
	assign rsp       = buf0_q;
	assign pop       = rsp_valid && !rsp_stall;
	assign advance   = lookup.vld && ((buf_cnt_q == 2'd0) || ((buf_cnt_q == 2'd1) && pop));

	// append the code under the pending bits and cut out whole bytes
	assign acc     = (hcbp_pkg::ACC_W'(pend_bits_q) << lookup.len) |
		hcbp_pkg::ACC_W'(lookup.code);
	assign total   = hcbp_pkg::TOT_W'(pend_cnt_q) + hcbp_pkg::TOT_W'(lookup.len);
	assign n_bytes = (32'(total) >= 2 * hcbp_pkg::BYTE_BITS) ? 2'd2 :
		(32'(total) >= hcbp_pkg::BYTE_BITS) ? 2'd1 : 2'd0;
	assign rem     = total - hcbp_pkg::TOT_W'(n_bytes) * hcbp_pkg::TOT_W'(hcbp_pkg::BYTE_BITS);
	assign rem_mask = (hcbp_pkg::ACC_W'(1) << rem) - hcbp_pkg::ACC_W'(1);
	assign byte_hi = hcbp_pkg::BYTE_BITS'(acc >>
		(total - hcbp_pkg::TOT_W'(hcbp_pkg::BYTE_BITS)));
	assign byte_lo = hcbp_pkg::BYTE_BITS'(acc >>
		(total - hcbp_pkg::TOT_W'(2 * hcbp_pkg::BYTE_BITS)));

	assign flush_sh   = (hcbp_pkg::CNT_W+1)'(hcbp_pkg::BYTE_BITS) - {1'b0, pend_cnt_q};
	assign flush_byte = hcbp_pkg::BYTE_BITS'(hcbp_pkg::BYTE_BITS'(pend_bits_q) << flush_sh);

	always_comb begin
		n_new       = 2'd0;
		r0          = '0;
		r1          = '0;
		pend_bits_d = pend_bits_q;
		pend_cnt_d  = pend_cnt_q;
		case (lookup.opcode)
			hcbp_pkg::OP_ENCODE: begin
				if (!lookup.loaded) begin
					n_new             = 2'd1;
					r0.last_of_run    = 1'b1;
					r0.unknown_symbol = 1'b1;
				end else begin
					n_new          = n_bytes;
					r0.out_byte    = byte_hi;
					r0.last_of_run = (n_bytes == 2'd1);
					r1.out_byte    = byte_lo;
					r1.last_of_run = 1'b1;
					pend_bits_d    = hcbp_pkg::PEND_W'(acc & rem_mask);
					pend_cnt_d     = hcbp_pkg::CNT_W'(rem);
				end
			end
			hcbp_pkg::OP_FLUSH: begin
				if (pend_cnt_q != '0) begin
					n_new           = 2'd1;
					r0.out_byte     = flush_byte;
					r0.last_of_run  = 1'b1;
					r0.padded_final = 1'b1;
					pend_bits_d     = '0;
					pend_cnt_d      = '0;
				end
			end
			default: begin
				n_new = 2'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
			buf_cnt_q   <= 2'd0;
		end else begin
			if (advance) begin
				pend_bits_q <= pend_bits_d;
				pend_cnt_q  <= pend_cnt_d;
				buf_cnt_q   <= n_new;
			end else if (pop) begin
				buf_cnt_q <= buf_cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			buf0_q <= r0;
			buf1_q <= r1;
		end else if (pop) begin
			buf0_q <= buf1_q;
		end
	end

	a_first_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(buf_cnt_q == 2'd2) |-> !buf0_q.last_of_run)
		else $error("first of two buffered bytes marked last");

	a_second_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop && (buf_cnt_q == 2'd2) |=> rsp_valid && rsp.last_of_run)
		else $error("second buffered byte not marked last");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (lookup.opcode == hcbp_pkg::OP_FLUSH) |=> (pend_cnt_q == '0))
		else $error("packer not empty after flush");

endmodule

`default_nettype wire

// ===== design/huffman_code_bit_packer.sv =====
// top level of the huffman code bit packer
// Request channel (req_valid, req_stall, req) carries load, encode and flush
// transactions; the response channel (rsp_valid, rsp_stall, rsp) carries
// packed bytes, earliest code bit in the msb.
// A load writes one code table entry and gives no response. An encode looks
// the symbol up and gives zero, one or two bytes, or one unknown_symbol
// response. A flush pads the partial byte with zeros and gives it out.
// The table ram is read at the accepting edge into the lookup stage, and the
// packer then registers the response into the result buffer when it advances.
// Throughput: one transaction per cycle while each gives at most one byte and
// rsp_stall is low; a transaction that gives two bytes holds the two-entry
// result buffer until its second byte leaves through the single response port.
// Reset clears the loaded marks and the packer; the table ram itself is not
// cleared and an entry's code is only used once it has been loaded.
// While rsp_stall is high the response holds; req_stall rises once the lookup
// stage holds a transaction that cannot move into a non-emptying result buffer.
`default_nettype none

module huffman_code_bit_packer (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire hcbp_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output hcbp_pkg::rsp_t      rsp
);

	hcbp_pkg::lookup_t lookup;
	logic              advance;

	hcbp_table u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_stall (req_stall),
		.advance   (advance),
		.lookup    (lookup)
	);

	hcbp_packer u_packer (
		.clk       (clk),
		.arst_n    (arst_n),
		.lookup    (lookup),
		.advance   (advance),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// self-checking testbench for the huffman code bit packer: random and directed traffic
`timescale 1ns / 1ps

module testbench;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_ITEMS = 1350;
	localparam int DRAIN_CYCLES = 16;

	// predicts the packed byte stream and checks the response transactions against it
	class packed_byte_scoreboard;
		logic [hcbp_pkg::CODE_W-1:0] code_tbl [hcbp_pkg::ALPHABET_SIZE];
		logic [hcbp_pkg::LEN_W-1:0]  len_tbl  [hcbp_pkg::ALPHABET_SIZE];
		bit                          loaded   [hcbp_pkg::ALPHABET_SIZE];
		logic [hcbp_pkg::PEND_W-1:0] part_bits;
		logic [hcbp_pkg::CNT_W-1:0]  part_cnt;
		hcbp_pkg::rsp_t              awaited_bytes[$];
		int                          errors;
		int                          n_checked;
		int                          n_unknown;
		int                          op_seen[4];

		function new();
			foreach (loaded[i]) loaded[i] = 1'b0;
			part_bits = '0;
			part_cnt = '0;
			errors = 0;
			n_checked = 0;
			n_unknown = 0;
			foreach (op_seen[i]) op_seen[i] = 0;
		endfunction

		function void expect_byte(hcbp_pkg::rsp_t b);
			awaited_bytes = {awaited_bytes, b};
		endfunction

		function void note_request(hcbp_pkg::req_t r);
			logic [hcbp_pkg::ACC_W-1:0] acc;
			logic [31:0]                mask;
			int                         clen;
			int                         total;
			int                         n;
			hcbp_pkg::rsp_t             outs[2];
			op_seen[r.opcode]++;
			case (r.opcode)
				hcbp_pkg::OP_LOAD: begin
					if (int'(r.symbol) < hcbp_pkg::ALPHABET_SIZE) begin
						clen = int'(r.code_length);
						if (clen > hcbp_pkg::LEN_CAP) clen = hcbp_pkg::LEN_CAP;
						mask = (32'd1 << clen) - 32'd1;
						code_tbl[r.symbol] = r.code_value & mask[hcbp_pkg::CODE_W-1:0];
						len_tbl[r.symbol] = hcbp_pkg::LEN_W'(clen);
						loaded[r.symbol] = 1'b1;
					end
				end
				hcbp_pkg::OP_ENCODE: begin
					if (int'(r.symbol) >= hcbp_pkg::ALPHABET_SIZE || !loaded[r.symbol]) begin
						outs[0] = '{out_byte: '0, last_of_run: 1'b1,
							unknown_symbol: 1'b1, padded_final: 1'b0};
						expect_byte(outs[0]);
					end else begin
						clen = int'(len_tbl[r.symbol]);
						acc = (hcbp_pkg::ACC_W'(part_bits) << clen) |
							hcbp_pkg::ACC_W'(code_tbl[r.symbol]);
						total = int'(part_cnt) + clen;
						n = 0;
						while (total >= hcbp_pkg::BYTE_BITS && n < 2) begin
							outs[n] = '{out_byte: hcbp_pkg::BYTE_BITS'(acc >>
								(total - hcbp_pkg::BYTE_BITS)),
								last_of_run: 1'b0, unknown_symbol: 1'b0,
								padded_final: 1'b0};
							total -= hcbp_pkg::BYTE_BITS;
							n++;
						end
						if (n > 0) outs[n-1].last_of_run = 1'b1;
						for (int k = 0; k < n; k++) expect_byte(outs[k]);
						mask = (32'd1 << total) - 32'd1;
						part_bits = hcbp_pkg::PEND_W'(acc & hcbp_pkg::ACC_W'(mask));
						part_cnt = hcbp_pkg::CNT_W'(total);
					end
				end
				hcbp_pkg::OP_FLUSH: begin
					if (part_cnt != 0) begin
						outs[0] = '{out_byte: hcbp_pkg::BYTE_BITS'(16'(part_bits) <<
							(hcbp_pkg::BYTE_BITS - int'(part_cnt))),
							last_of_run: 1'b1, unknown_symbol: 1'b0,
							padded_final: 1'b1};
						expect_byte(outs[0]);
						part_bits = '0;
						part_cnt = '0;
					end
				end
				default: ;
			endcase
		endfunction

		function void check_byte(hcbp_pkg::rsp_t got);
			hcbp_pkg::rsp_t want;
			n_checked++;
			if (awaited_bytes.size() == 0) begin
				$error("response with nothing awaited: %p", got);
				errors++;
				return;
			end
			want = awaited_bytes.pop_front();
			if (want.unknown_symbol) n_unknown++;
			if (got.out_byte !== want.out_byte) begin
				$error("out_byte: expected %02h, actual %02h", want.out_byte, got.out_byte);
				errors++;
			end
			if (got.last_of_run !== want.last_of_run) begin
				$error("last_of_run: expected %0b, actual %0b",
					want.last_of_run, got.last_of_run);
				errors++;
			end
			if (got.unknown_symbol !== want.unknown_symbol) begin
				$error("unknown_symbol: expected %0b, actual %0b",
					want.unknown_symbol, got.unknown_symbol);
				errors++;
			end
			if (got.padded_final !== want.padded_final) begin
				$error("padded_final: expected %0b, actual %0b",
					want.padded_final, got.padded_final);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	hcbp_pkg::req_t req_d = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	hcbp_pkg::rsp_t rsp_q;

	packed_byte_scoreboard sb = new();
	bit   no_idle = 1'b0;
	int   cycle_count = 0;
	logic [hcbp_pkg::SYM_W-1:0] table_syms[$];
	bit   in_table[hcbp_pkg::ALPHABET_SIZE];

	huffman_code_bit_packer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req_d),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp_q)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// values read here are the ones from just before the edge
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timed out after %0d cycles", cycle_count);
			$display("DONE: errors detected");
			$finish;
		end
		if (arst_n) begin
			if (req_valid && !req_stall) sb.note_request(req_d);
			if (rsp_valid && !rsp_stall) sb.check_byte(rsp_q);
		end
	end

	function automatic int pick_gap();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic hcbp_pkg::req_t make_req(logic [1:0] op,
		logic [hcbp_pkg::SYM_W-1:0] sym, logic [hcbp_pkg::CODE_W-1:0] val,
		logic [hcbp_pkg::LEN_W-1:0] len);
		hcbp_pkg::req_t r;
		r.opcode = op;
		r.symbol = sym;
		r.code_value = val;
		r.code_length = len;
		return r;
	endfunction

	task automatic send_request(input hcbp_pkg::req_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_d <= r;
		if (r.opcode == hcbp_pkg::OP_LOAD && !in_table[r.symbol]) begin
			in_table[r.symbol] = 1'b1;
			table_syms = {table_syms, r.symbol};
		end
		do @(posedge clk); while (req_stall);
	endtask

	// symbols 192..254 are never loaded so that unknown encodes stay possible
	function automatic hcbp_pkg::req_t random_request();
		hcbp_pkg::req_t r;
		int             pick;
		int             s;
		r = make_req(hcbp_pkg::OP_NONE, hcbp_pkg::SYM_W'($urandom),
			hcbp_pkg::CODE_W'($urandom), hcbp_pkg::LEN_W'($urandom));
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			s = $urandom_range(0, 192);
			r.opcode = hcbp_pkg::OP_LOAD;
			r.symbol = (s == 192) ? 8'd255 : hcbp_pkg::SYM_W'(s);
			s = $urandom_range(0, 9);
			if (s == 0) r.code_length = '0;
			else if (s == 1) r.code_length = hcbp_pkg::LEN_W'($urandom_range(17, 31));
			else r.code_length = hcbp_pkg::LEN_W'($urandom_range(1, 16));
		end else if (pick < 80) begin
			r.opcode = hcbp_pkg::OP_ENCODE;
			r.symbol = table_syms[$urandom_range(0, table_syms.size() - 1)];
		end else if (pick < 86) begin
			r.opcode = hcbp_pkg::OP_ENCODE;
			r.symbol = hcbp_pkg::SYM_W'($urandom_range(192, 254));
		end else if (pick < 95) begin
			r.opcode = hcbp_pkg::OP_FLUSH;
		end
		return r;
	endfunction

	initial begin : rsp_stall_gen
		int run;
		forever begin
			run = $urandom_range(1, 6);
			rsp_stall <= 1'b0;
			repeat (run) @(posedge clk);
			run = pick_gap();
			if (run > 0) begin
				rsp_stall <= 1'b1;
				repeat (run) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int             sent;
		hcbp_pkg::req_t r;
		foreach (in_table[i]) in_table[i] = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner cases on an empty table and packer
		send_request(make_req(hcbp_pkg::OP_FLUSH,  8'd0,   16'h0000, 5'd0));
		send_request(make_req(hcbp_pkg::OP_ENCODE, 8'd0,   16'hFFFF, 5'd31));
		send_request(make_req(hcbp_pkg::OP_NONE,   8'd255, 16'hFFFF, 5'd31));
		send_request(make_req(hcbp_pkg::OP_LOAD,   8'd0,   16'hFFFF, 5'd16));
		send_request(make_req(hcbp_pkg::OP_LOAD,   8'd255, 16'h0000, 5'd1));
		send_request(make_req(hcbp_pkg::OP_LOAD,   8'd1,   16'hABCD, 5'd0));
		send_request(make_req(hcbp_pkg::OP_LOAD,   8'd2,   16'hFFFF, 5'd31));
		send_request(make_req(hcbp_pkg::OP_LOAD,   8'd3,   16'h1235, 5'd3));
		send_request(make_req(hcbp_pkg::OP_LOAD,   8'd4,   16'h005A, 5'd7));
		send_request(make_req(hcbp_pkg::OP_LOAD,   8'd5,   16'h8001, 5'd17));
		// zero-length code, two encodes giving two bytes each, then flushes and more encodes
		send_request(make_req(hcbp_pkg::OP_ENCODE, 8'd1,   16'h0000, 5'd0));
		send_request(make_req(hcbp_pkg::OP_ENCODE, 8'd3,   16'h0000, 5'd0));
		send_request(make_req(hcbp_pkg::OP_ENCODE, 8'd0,   16'h0000, 5'd0));
		send_request(make_req(hcbp_pkg::OP_ENCODE, 8'd2,   16'hFFFF, 5'd31));
		send_request(make_req(hcbp_pkg::OP_ENCODE, 8'd255, 16'h0000, 5'd0));
		send_request(make_req(hcbp_pkg::OP_FLUSH,  8'd0,   16'h0000, 5'd0));
		send_request(make_req(hcbp_pkg::OP_FLUSH,  8'd255, 16'hFFFF, 5'd31));
		send_request(make_req(hcbp_pkg::OP_ENCODE, 8'd4,   16'h0000, 5'd0));
		send_request(make_req(hcbp_pkg::OP_ENCODE, 8'd4,   16'h0000, 5'd0));
		send_request(make_req(hcbp_pkg::OP_ENCODE, 8'd0,   16'h0000, 5'd0));
		// unknown symbol with a partial byte pending leaves the packer alone
		send_request(make_req(hcbp_pkg::OP_ENCODE, 8'd200, 16'h0000, 5'd0));
		send_request(make_req(hcbp_pkg::OP_ENCODE, 8'd5,   16'h0000, 5'd0));
		send_request(make_req(hcbp_pkg::OP_FLUSH,  8'd0,   16'h0000, 5'd0));
		send_request(make_req(hcbp_pkg::OP_NONE,   8'd0,   16'h0000, 5'd0));

		// build up a table before mostly encoding against it
		for (int i = 0; i < 40; i++) begin
			r = random_request();
			r.opcode = hcbp_pkg::OP_LOAD;
			r.symbol = hcbp_pkg::SYM_W'($urandom_range(0, 191));
			r.code_length = hcbp_pkg::LEN_W'($urandom_range(1, 16));
			send_request(r);
		end
		sent = 40;
		while (sent < RANDOM_ITEMS) begin
			no_idle = (sent >= 500 && sent < 800);
			r = random_request();
			send_request(r);
			if (r.opcode != hcbp_pkg::OP_NONE) sent++;
		end
		no_idle = 1'b0;
		req_valid <= 1'b0;

		while (sb.awaited_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d loads, %0d encodes, %0d flushes, %0d ignored transactions",
			sb.op_seen[hcbp_pkg::OP_LOAD], sb.op_seen[hcbp_pkg::OP_ENCODE],
			sb.op_seen[hcbp_pkg::OP_FLUSH], sb.op_seen[hcbp_pkg::OP_NONE]);
		$display("checked %0d response bytes, %0d of them unknown-symbol, in %0d cycles",
			sb.n_checked, sb.n_unknown, cycle_count);
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
design/hcbp_pkg.sv
design/hcbp_ram.sv
design/hcbp_table.sv
design/hcbp_packer.sv
design/huffman_code_bit_packer.sv
sim/testbench.sv
